// ===== src/kbp_pkg.sv =====
// Shared types and constants for the keys atom byte parser.
`default_nettype none
package kbp_pkg;

    // Result kinds
    localparam logic [2:0] KIND_VERSION = 3'd0;
    localparam logic [2:0] KIND_FLAG    = 3'd1;
    localparam logic [2:0] KIND_COUNT   = 3'd2;
    localparam logic [2:0] KIND_HEADER  = 3'd3;
    localparam logic [2:0] KIND_NAME    = 3'd4;
    localparam logic [2:0] KIND_BADSIZE = 3'd5;

    // Key entry layout
    localparam logic [31:0] MIN_KEY_SIZE     = 32'd8;
    localparam logic [31:0] SIZE_FIELD_BYTES = 32'd4;

    // One result transaction
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] value;
        logic [31:0] key_number;
        logic        name_done;
    } t_result;

endpackage
`default_nettype wire

// ===== src/kbp_parser.sv =====
// Parse state registers and the per-byte next-state and result logic.
`default_nettype none
module kbp_parser (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic             i_start_of_atom,
    input  wire logic [7:0]       i_data_byte,
    output logic                  o_res_valid,
    output kbp_pkg::t_result      o_res
);
    import kbp_pkg::*;

    // Parse phases
    localparam logic [4:0] PH_VERSION    = 5'd0;
    localparam logic [4:0] PH_FLAG_LAST  = 5'd3;
    localparam logic [4:0] PH_COUNT_LAST = 5'd7;
    localparam logic [4:0] PH_SIZE_FIRST = 5'd8;
    localparam logic [4:0] PH_SIZE_LAST  = 5'd11;
    localparam logic [4:0] PH_TYPE_LAST  = 5'd15;
    localparam logic [4:0] PH_NAME       = 5'd16;

    logic [4:0]  r_phase, n_phase, e_phase;
    logic [31:0] r_entry_count, n_entry_count, e_entry_count;
    logic [31:0] r_bytes_left, n_bytes_left, e_bytes_left;
    logic [31:0] r_type_word, n_type_word, e_type_word;
    logic [31:0] r_key_counter, n_key_counter, e_key_counter;
    logic        r_failed, n_failed, e_failed;
    logic [31:0] size_shift;
    logic [31:0] left_dec;

    // Work out the next state and the result for the byte on offer
    always_comb begin
        e_phase       = r_phase;
        e_entry_count = r_entry_count;
        e_bytes_left  = r_bytes_left;
        e_type_word   = r_type_word;
        e_key_counter = r_key_counter;
        e_failed      = r_failed;
        if (i_start_of_atom) begin
            e_phase       = PH_VERSION;
            e_entry_count = '0;
            e_bytes_left  = '0;
            e_type_word   = '0;
            e_key_counter = '0;
            e_failed      = 1'b0;
        end

        size_shift = {e_bytes_left[23:0], i_data_byte};
        left_dec   = e_bytes_left - 32'd1;

        n_phase       = r_phase;
        n_entry_count = r_entry_count;
        n_bytes_left  = r_bytes_left;
        n_type_word   = r_type_word;
        n_key_counter = r_key_counter;
        n_failed      = r_failed;

        o_res_valid          = 1'b0;
        o_res.kind           = KIND_VERSION;
        o_res.value          = {24'd0, i_data_byte};
        o_res.key_number     = e_key_counter;
        o_res.name_done      = 1'b0;

        if (i_accept) begin
            n_phase       = e_phase;
            n_entry_count = e_entry_count;
            n_bytes_left  = e_bytes_left;
            n_type_word   = e_type_word;
            n_key_counter = e_key_counter;
            n_failed      = e_failed;

            priority if (e_failed || e_phase > PH_NAME) begin
                // drop the byte
                n_phase = e_phase;
            end else if (e_phase == PH_VERSION) begin
                n_phase     = e_phase + 5'd1;
                o_res_valid = (i_data_byte != 8'd0);
                o_res.kind  = KIND_VERSION;
            end else if (e_phase <= PH_FLAG_LAST) begin
                n_phase     = e_phase + 5'd1;
                o_res_valid = (i_data_byte != 8'd0);
                o_res.kind  = KIND_FLAG;
            end else if (e_phase <= PH_COUNT_LAST) begin
                n_entry_count = {e_entry_count[23:0], i_data_byte};
                if (e_phase == PH_COUNT_LAST) begin
                    n_phase     = PH_SIZE_FIRST;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_COUNT;
                    o_res.value = n_entry_count;
                end else begin
                    n_phase = e_phase + 5'd1;
                end
            end else if (e_phase <= PH_SIZE_LAST) begin
                n_bytes_left = size_shift;
                n_phase      = e_phase + 5'd1;
                if (e_phase == PH_SIZE_LAST) begin
                    if (size_shift < MIN_KEY_SIZE) begin
                        // undersized entry: report once, then ignore bytes
                        n_failed    = 1'b1;
                        n_phase     = e_phase;
                        o_res_valid = 1'b1;
                        o_res.kind  = KIND_BADSIZE;
                        o_res.value = size_shift;
                    end else begin
                        n_bytes_left = size_shift - SIZE_FIELD_BYTES;
                    end
                end
            end else if (e_phase <= PH_TYPE_LAST) begin
                n_type_word  = {e_type_word[23:0], i_data_byte};
                n_bytes_left = left_dec;
                if (e_phase == PH_TYPE_LAST) begin
                    n_key_counter    = e_key_counter + 32'd1;
                    n_phase          = (left_dec == 32'd0) ? PH_SIZE_FIRST : PH_NAME;
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_HEADER;
                    o_res.value      = n_type_word;
                    o_res.key_number = n_key_counter;
                    o_res.name_done  = (left_dec == 32'd0);
                end else begin
                    n_phase = e_phase + 5'd1;
                end
            end else begin
                // name byte
                n_bytes_left    = left_dec;
                n_phase         = (left_dec == 32'd0) ? PH_SIZE_FIRST : PH_NAME;
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_NAME;
                o_res.name_done = (left_dec == 32'd0);
            end
        end
    end

    // Hold the parse state between bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_VERSION;
            r_entry_count <= '0;
            r_bytes_left  <= '0;
            r_type_word   <= '0;
            r_key_counter <= '0;
            r_failed      <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_entry_count <= n_entry_count;
            r_bytes_left  <= n_bytes_left;
            r_type_word   <= n_type_word;
            r_key_counter <= n_key_counter;
            r_failed      <= n_failed;
        end
    end

endmodule
`default_nettype wire

// ===== src/kbp_out_buf.sv =====
// Result register with a skid entry behind it.
`default_nettype none
module kbp_out_buf (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_res_valid,
    input  wire kbp_pkg::t_result i_res,
    input  wire logic             i_stall,
    output logic                  o_valid,
    output kbp_pkg::t_result      o_res,
    output logic                  o_full
);
    import kbp_pkg::*;

    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    take;

    // Advance the result register when it is empty or being taken
    always_comb begin
        take         = r_out_valid && !i_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid       = i_res;
                n_skid_valid = i_res_valid;
            end else begin
                n_out       = i_res;
                n_out_valid = i_res_valid;
            end
        end else if (i_res_valid) begin
            n_skid       = i_res;
            n_skid_valid = 1'b1;
        end
    end

    // Control flags take reset; payload does not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;
    assign o_full  = r_skid_valid;

endmodule
`default_nettype wire

// ===== src/keys_atom_byte_parser_core.sv =====
// Top level of the keys atom byte parser: parse logic and result buffer.
// Output: each result is registered, in the skid entry while a stalled one waits.
// Throughput: one byte per cycle; the result register plus one skid entry
// let input continue while a result waits, and o_stall rises only when both hold.
// Reset: synchronous, active low; clears parse state to expect a version byte
// and empties the result buffer.
`default_nettype none
module keys_atom_byte_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_start_of_atom,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_kind,
    output logic [31:0]      o_value,
    output logic [31:0]      o_key_number,
    output logic             o_name_done
);
    import kbp_pkg::*;

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    buf_full;

    // Take a transaction whenever the skid entry is free
    assign o_stall = buf_full;
    assign accept  = i_valid && !buf_full;

    kbp_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_start_of_atom (i_start_of_atom),
        .i_data_byte     (i_data_byte),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    kbp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (out_res),
        .o_full      (buf_full)
    );

    assign o_kind       = out_res.kind;
    assign o_value      = out_res.value;
    assign o_key_number = out_res.key_number;
    assign o_name_done  = out_res.name_done;

endmodule
`default_nettype wire

// ===== src/kbp_checker.sv =====
// Port-level checks for the keys atom byte parser, bound to the top level.
`default_nettype none
module kbp_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_stall,
    input  wire logic        o_valid,
    input  wire logic        i_stall,
    input  wire logic [2:0]  o_kind,
    input  wire logic [31:0] o_value,
    input  wire logic [31:0] o_key_number,
    input  wire logic        o_name_done
);
    import kbp_pkg::*;

    // Result buffer is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("result or stall present after reset");

    // Upstream is held only while a result waits
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // Last-name mark only on key headers and name bytes
    a_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_name_done) |-> (o_kind == KIND_HEADER || o_kind == KIND_NAME))
        else $error("name_done on wrong result kind");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_kind) && $stable(o_value)
            && $stable(o_key_number) && $stable(o_name_done)))
        else $error("stalled result changed");

    // Byte-sized kinds carry a byte value
    a_byte_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_VERSION || o_kind == KIND_FLAG || o_kind == KIND_NAME))
            |-> (o_value[31:8] == 24'd0))
        else $error("byte result wider than a byte");

endmodule

bind keys_atom_byte_parser_core kbp_checker u_kbp_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_kind       (o_kind),
    .o_value      (o_value),
    .o_key_number (o_key_number),
    .o_name_done  (o_name_done)
);
`default_nettype wire

// ===== verif/keys_result_checker.sv =====
// Result checker for the keys atom byte parser: predicts each result and compares it.
module keys_result_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic        i_start_of_atom,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [2:0]  i_kind,
    input  wire logic [31:0] i_value,
    input  wire logic [31:0] i_key_number,
    input  wire logic        i_name_done,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_bytes_seen,
    output int               o_result_total,
    output int               o_header_total,
    output int               o_name_total,
    output int               o_badsize_total
);
    import kbp_pkg::*;

    // Parse positions within the atom body
    localparam logic [4:0] PH_VERSION    = 5'd0;
    localparam logic [4:0] PH_FLAG_LAST  = 5'd3;
    localparam logic [4:0] PH_COUNT_LAST = 5'd7;
    localparam logic [4:0] PH_SIZE_FIRST = 5'd8;
    localparam logic [4:0] PH_SIZE_LAST  = 5'd11;
    localparam logic [4:0] PH_TYPE_LAST  = 5'd15;
    localparam logic [4:0] PH_NAME       = 5'd16;

    logic [4:0]  parse_pos;
    logic [31:0] count_acc;
    logic [31:0] entry_left;
    logic [31:0] type_acc;
    logic [31:0] keys_seen;
    logic        size_failed;

    t_result     expected_results[$];
    t_result     predicted;
    logic        predicted_valid;
    logic        mismatch;
    int          fail_total;
    int          bytes_total;
    int          result_total;
    int          header_total;
    int          name_total;
    int          badsize_total;

    task automatic clear_parse();
        parse_pos   = PH_VERSION;
        count_acc   = '0;
        entry_left  = '0;
        type_acc    = '0;
        keys_seen   = '0;
        size_failed = 1'b0;
    endtask

    function automatic t_result make_result(input logic [2:0] kind, input logic [31:0] value,
                                            input logic done);
        t_result r;
        r.kind       = kind;
        r.value      = value;
        r.key_number = keys_seen;
        r.name_done  = done;
        return r;
    endfunction

    // Advance the parse by one byte; flag and return the result it causes, if any
    task automatic parse_keys_byte(input logic sop, input logic [7:0] b,
                                   output logic got, output t_result r);
        got = 1'b0;
        r   = '0;
        if (sop)
            clear_parse();
        if (size_failed || parse_pos > PH_NAME) begin
            // drop bytes until the next atom start
        end else if (parse_pos == PH_VERSION) begin
            parse_pos = parse_pos + 5'd1;
            if (b != 8'd0) begin
                got = 1'b1;
                r   = make_result(KIND_VERSION, {24'd0, b}, 1'b0);
            end
        end else if (parse_pos <= PH_FLAG_LAST) begin
            parse_pos = parse_pos + 5'd1;
            if (b != 8'd0) begin
                got = 1'b1;
                r   = make_result(KIND_FLAG, {24'd0, b}, 1'b0);
            end
        end else if (parse_pos <= PH_COUNT_LAST) begin
            count_acc = {count_acc[23:0], b};
            if (parse_pos == PH_COUNT_LAST) begin
                parse_pos = PH_SIZE_FIRST;
                got       = 1'b1;
                r         = make_result(KIND_COUNT, count_acc, 1'b0);
            end else begin
                parse_pos = parse_pos + 5'd1;
            end
        end else if (parse_pos <= PH_SIZE_LAST) begin
            entry_left = {entry_left[23:0], b};
            if (parse_pos == PH_SIZE_LAST && entry_left < MIN_KEY_SIZE) begin
                size_failed = 1'b1;
                got         = 1'b1;
                r           = make_result(KIND_BADSIZE, entry_left, 1'b0);
            end else begin
                if (parse_pos == PH_SIZE_LAST)
                    entry_left = entry_left - SIZE_FIELD_BYTES;
                parse_pos = parse_pos + 5'd1;
            end
        end else if (parse_pos <= PH_TYPE_LAST) begin
            type_acc   = {type_acc[23:0], b};
            entry_left = entry_left - 32'd1;
            if (parse_pos == PH_TYPE_LAST) begin
                keys_seen = keys_seen + 32'd1;
                parse_pos = (entry_left == 32'd0) ? PH_SIZE_FIRST : PH_NAME;
                got       = 1'b1;
                r         = make_result(KIND_HEADER, type_acc, entry_left == 32'd0);
            end else begin
                parse_pos = parse_pos + 5'd1;
            end
        end else begin
            entry_left = entry_left - 32'd1;
            got        = 1'b1;
            r          = make_result(KIND_NAME, {24'd0, b}, entry_left == 32'd0);
            if (entry_left == 32'd0)
                parse_pos = PH_SIZE_FIRST;
        end
    endtask

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, seen);
            mismatch = 1'b1;
        end
    endtask

    // Compare each result transaction with the oldest expectation, then predict
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            expected_results.delete();
            fail_total    = 0;
            bytes_total   = 0;
            result_total  = 0;
            header_total  = 0;
            name_total    = 0;
            badsize_total = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                result_total++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual kind %0d value 0x%0h",
                             $time, i_kind, i_value);
                    fail_total++;
                end else begin
                    predicted = expected_results.pop_front();
                    mismatch  = 1'b0;
                    report_field("kind", {29'd0, predicted.kind}, {29'd0, i_kind});
                    report_field("value", predicted.value, i_value);
                    report_field("key_number", predicted.key_number, i_key_number);
                    report_field("name_done", {31'd0, predicted.name_done}, {31'd0, i_name_done});
                    if (mismatch)
                        fail_total++;
                    if (predicted.kind == KIND_HEADER)
                        header_total++;
                    if (predicted.kind == KIND_NAME)
                        name_total++;
                    if (predicted.kind == KIND_BADSIZE)
                        badsize_total++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                bytes_total++;
                parse_keys_byte(i_start_of_atom, i_data_byte, predicted_valid, predicted);
                if (predicted_valid)
                    expected_results.push_back(predicted);
            end
        end
        o_fail_count    <= fail_total;
        o_pending       <= expected_results.size();
        o_bytes_seen    <= bytes_total;
        o_result_total  <= result_total;
        o_header_total  <= header_total;
        o_name_total    <= name_total;
        o_badsize_total <= badsize_total;
    end

endmodule

// ===== verif/testbench.sv =====
// Top of the keys atom byte parser testbench: clock, reset, byte stimulus and verdict.
module testbench;
    import kbp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 170;
    localparam int PHASE_COUNT    = 8;
    localparam int DRAIN_CYCLES   = 8;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        byte_valid = 1'b0;
    logic        atom_start = 1'b0;
    logic [7:0]  atom_byte  = 8'd0;
    logic        res_stall  = 1'b0;

    wire logic        byte_stall;
    wire logic        res_valid;
    wire logic [2:0]  res_kind;
    wire logic [31:0] res_value;
    wire logic [31:0] res_key_number;
    wire logic        res_name_done;

    int fail_count;
    int pending;
    int bytes_seen;
    int result_total;
    int header_total;
    int name_total;
    int badsize_total;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int useful_bytes    = 0;
    int quiet_cycles    = 0;

    keys_atom_byte_parser_core u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (byte_valid),
        .o_stall         (byte_stall),
        .i_start_of_atom (atom_start),
        .i_data_byte     (atom_byte),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_kind          (res_kind),
        .o_value         (res_value),
        .o_key_number    (res_key_number),
        .o_name_done     (res_name_done)
    );

    keys_result_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (byte_valid),
        .i_in_stall      (byte_stall),
        .i_start_of_atom (atom_start),
        .i_data_byte     (atom_byte),
        .i_out_valid     (res_valid),
        .i_out_stall     (res_stall),
        .i_kind          (res_kind),
        .i_value         (res_value),
        .i_key_number    (res_key_number),
        .i_name_done     (res_name_done),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_seen    (bytes_seen),
        .o_result_total  (result_total),
        .o_header_total  (header_total),
        .o_name_total    (name_total),
        .o_badsize_total (badsize_total)
    );

    always #5 clk = ~clk;

    // Stall the result channel at random
    always @(posedge clk) begin
        res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Abort when neither channel moves a transaction for too long
    always @(posedge clk) begin
        if ((byte_valid && !byte_stall) || (res_valid && !res_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d results outstanding", $time, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Offer one byte after a random gap and hold it until taken
    task automatic send_byte(input logic sop, input logic [7:0] b, input bit counted);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
        byte_valid <= 1'b1;
        atom_start <= sop;
        atom_byte  <= b;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        if (counted)
            useful_bytes++;
    endtask

    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(1'b0, w[i*8 +: 8], 1'b1);
    endtask

    // Hold off the sender until every expected result has come out
    task automatic drain_results();
        byte_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly well formed atoms with random content; some cut short or broken
    task automatic random_atom();
        int          n_keys;
        int          choice;
        int          name_len;
        bit          cut;
        logic [31:0] trunc_size;
        cut = 1'b0;
        send_byte(1'b1, ($urandom_range(0, 99) < 20) ? 8'($urandom_range(1, 255)) : 8'd0, 1'b1);
        repeat (3)
            send_byte(1'b0, ($urandom_range(0, 99) < 15) ? 8'($urandom_range(1, 255)) : 8'd0,
                      1'b1);
        send_word(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6));
        n_keys = $urandom_range(0, 6);
        for (int k = 0; k < n_keys && !cut; k++) begin
            choice = $urandom_range(0, 99);
            if (choice < 7) begin
                // invalid size, then bytes the block should drop
                send_word($urandom_range(0, 7));
                repeat ($urandom_range(0, 4))
                    send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b0);
                cut = 1'b1;
            end else if (choice < 14) begin
                // entry cut short by the next atom start
                trunc_size = $urandom_range(0, 1) ? ($urandom | 32'h8000_0000)
                                                  : 32'd8 + $urandom_range(0, 64);
                send_word(trunc_size);
                repeat ($urandom_range(0, 9))
                    send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);
                cut = 1'b1;
            end else begin
                name_len = (choice < 20) ? $urandom_range(20, 60) : $urandom_range(0, 12);
                send_word(32'd8 + name_len);
                send_word($urandom);
                repeat (name_len)
                    send_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);
            end
        end
        // stray bytes between atoms, occasionally with a start flag
        if (!cut && $urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
                send_byte($urandom_range(0, 9) == 0, 8'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    initial begin
        int target;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: version and flag reports, count extreme, empty name, one name byte,
        // invalid size and a dropped byte after it
        send_byte(1'b1, 8'hFF, 1'b1);
        send_byte(1'b0, 8'h01, 1'b1);
        send_byte(1'b0, 8'h00, 1'b1);
        send_byte(1'b0, 8'h80, 1'b1);
        send_word(32'hFFFF_FFFF);
        send_word(32'd8);
        send_word(32'h6D64_7461);
        send_word(32'd9);
        send_word(32'h0000_0000);
        send_byte(1'b0, 8'h00, 1'b1);
        send_word(32'd7);
        send_byte(1'b0, 8'hFF, 1'b0);
        drain_results();

        // Random atoms across the idling phases
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                0: begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 0;
                end
                1: begin
                    sender_idle_pct <= 56;
                    recv_stall_pct  <= 0;
                end
                2: begin
                    sender_idle_pct <= 0;
                    recv_stall_pct  <= 56;
                end
                default: begin
                    sender_idle_pct <= 19;
                    recv_stall_pct  <= 19;
                end
            endcase
            target = useful_bytes + PHASE_BYTES;
            while (useful_bytes < target)
                random_atom();
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d bytes in %0d idling phases, giving %0d results:",
                 bytes_seen, PHASE_COUNT, result_total);
        $display("%0d key headers, %0d name bytes, %0d invalid sizes; %0d failures.",
                 header_total, name_total, badsize_total, fail_count);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
